>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> src/mtss_pkg.sv
// ---------------------------------------------------------------------------
// mtss_pkg
// Types, codes and the scale table of the multi-track step sequencer.
// ---------------------------------------------------------------------------
package mtss_pkg;

    localparam logic [3:0] OP_TOGGLE    = 4'd0;
    localparam logic [3:0] OP_SET_NOTE  = 4'd1;
    localparam logic [3:0] OP_CLR_TRACK = 4'd2;
    localparam logic [3:0] OP_CLR_ALL   = 4'd3;
    localparam logic [3:0] OP_COPY      = 4'd4;
    localparam logic [3:0] OP_START     = 4'd5;
    localparam logic [3:0] OP_STOP      = 4'd6;
    localparam logic [3:0] OP_TICK      = 4'd7;
    localparam logic [3:0] OP_NOTE_OFF  = 4'd8;

    localparam logic [1:0] EV_NOTE_ON  = 2'd0;
    localparam logic [1:0] EV_NOTE_OFF = 2'd1;
    localparam logic [1:0] EV_ALL_OFF  = 2'd2;

    localparam logic [6:0] VEL_RESET  = 7'd76;
    localparam logic [6:0] NOTE_RESET = 7'd60;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] track;
        logic [3:0] step_index;
        logic [3:0] scale_index;
        logic [3:0] source_track;
    } in_word_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [3:0] event_track;
        logic [6:0] note_number;
        logic [6:0] velocity;
        logic       last;
    } out_word_t;

    typedef enum logic [3:0] {
        CMD_TOGGLE,
        CMD_SET_NOTE,
        CMD_CLR_TRACK,
        CMD_CLR_ALL,
        CMD_COPY,
        CMD_START,
        CMD_STOP,
        CMD_TICK,
        CMD_NOTE_OFF
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] trk;
        logic [3:0] src;
        logic [3:0] stp;
        logic [6:0] note;
    } cmd_t;

    function automatic logic [6:0] scale_note(input logic [3:0] idx);
        logic [6:0] n;
        case (idx)
            4'd0:    n = 7'd48;
            4'd1:    n = 7'd50;
            4'd2:    n = 7'd51;
            4'd3:    n = 7'd53;
            4'd4:    n = 7'd55;
            4'd5:    n = 7'd56;
            4'd6:    n = 7'd58;
            4'd7:    n = 7'd59;
            4'd8:    n = 7'd60;
            4'd9:    n = 7'd62;
            4'd10:   n = 7'd63;
            4'd11:   n = 7'd65;
            4'd12:   n = 7'd67;
            4'd13:   n = 7'd68;
            4'd14:   n = 7'd70;
            default: n = 7'd72;
        endcase
        return n;
    endfunction

endpackage

>>> src/mtss_ram.sv
// ---------------------------------------------------------------------------
// mtss_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mtss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/mtss_front.sv
// ---------------------------------------------------------------------------
// mtss_front
// Accepts input words, drops ones that do nothing, queues commands (2 deep).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mtss_front #(
    parameter int TRACKS = 16,
    parameter int STEPS  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  mtss_pkg::in_word_t item,
    output logic              cmd_valid,
    output mtss_pkg::cmd_t    cmd,
    input  logic              cmd_pop
);

    mtss_pkg::cmd_t q_reg [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     cnt_reg, cnt_next;

    mtss_pkg::cmd_t cls;
    logic           keep;
    logic           trk_ok, src_ok, stp_ok;
    logic           push;

    always_comb
    begin
        trk_ok     = 32'(item.track) < TRACKS;
        src_ok     = 32'(item.source_track) < TRACKS;
        stp_ok     = 32'(item.step_index) < STEPS;
        cls.trk    = item.track;
        cls.src    = item.source_track;
        cls.stp    = item.step_index;
        cls.note   = mtss_pkg::scale_note(item.scale_index);
        cls.kind   = mtss_pkg::CMD_TICK;
        keep       = 1'b0;
        unique case (item.op)
            mtss_pkg::OP_TOGGLE:
            begin
                cls.kind = mtss_pkg::CMD_TOGGLE;
                keep     = trk_ok && stp_ok;
            end
            mtss_pkg::OP_SET_NOTE:
            begin
                cls.kind = mtss_pkg::CMD_SET_NOTE;
                keep     = trk_ok && stp_ok;
            end
            mtss_pkg::OP_CLR_TRACK:
            begin
                cls.kind = mtss_pkg::CMD_CLR_TRACK;
                keep     = trk_ok;
            end
            mtss_pkg::OP_CLR_ALL:
            begin
                cls.kind = mtss_pkg::CMD_CLR_ALL;
                keep     = 1'b1;
            end
            mtss_pkg::OP_COPY:
            begin
                cls.kind = mtss_pkg::CMD_COPY;
                keep     = trk_ok && src_ok && (item.track != item.source_track);
            end
            mtss_pkg::OP_START:
            begin
                cls.kind = mtss_pkg::CMD_START;
                keep     = 1'b1;
            end
            mtss_pkg::OP_STOP:
            begin
                cls.kind = mtss_pkg::CMD_STOP;
                keep     = 1'b1;
            end
            mtss_pkg::OP_TICK:
            begin
                cls.kind = mtss_pkg::CMD_TICK;
                keep     = 1'b1;
            end
            mtss_pkg::OP_NOTE_OFF:
            begin
                cls.kind = mtss_pkg::CMD_NOTE_OFF;
                keep     = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign item_ready = (cnt_reg != 2'd2);
    assign push       = item_valid && item_ready && keep;
    assign cmd_valid  = (cnt_reg != 2'd0);
    assign cmd        = q_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ cmd_pop;
        cnt_next  = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= cls;
        end
    end

    `ASSERT_NEVER(a_q_no_overfill, clk, rst_n, cnt_reg == 2'd3)
    `ASSERT_NEVER(a_q_pop_empty, clk, rst_n, cmd_pop && (cnt_reg == 2'd0))

endmodule

>>> src/mtss_back.sv
// ---------------------------------------------------------------------------
// mtss_back
// Runs queued commands on the row-organized pattern and held stores. Ticks and
// note-offs scan a track per cycle unless the event output register stalls.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mtss_back #(
    parameter int TRACKS = 16,
    parameter int STEPS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [6:0]            cfg_data,
    input  logic                  cmd_valid,
    input  mtss_pkg::cmd_t        cmd,
    output logic                  cmd_pop,
    output logic                  evt_valid,
    input  logic                  evt_ready,
    output mtss_pkg::out_word_t   evt
);

    localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int SW = $clog2(STEPS);
    localparam int NW = STEPS * 7;
    localparam int HW = STEPS * 8;
    localparam logic [TW-1:0] LAST_TRK  = TW'(TRACKS - 1);
    localparam logic [SW-1:0] LAST_STEP = SW'(STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EDIT  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } bk_state_t;

    bk_state_t           state_reg, state_next;
    logic                playing_reg, playing_next;
    logic [SW-1:0]       pos_reg, pos_next;
    logic [SW-1:0]       fired_reg, fired_next;
    logic [6:0]          vel_reg, vel_next;
    logic [TRACKS-1:0]   act_vld_reg, act_vld_next;
    logic [TRACKS-1:0]   note_vld_reg, note_vld_next;
    logic [TRACKS-1:0]   held_vld_reg, held_vld_next;
    logic [TW-1:0]       cnt_reg, cnt_next;
    logic [TW-1:0]       rd_row_reg, rd_row_next;
    mtss_pkg::cmd_t      cur_reg, cur_next;
    logic                pend_vld_reg, pend_vld_next;
    mtss_pkg::out_word_t pend_reg, pend_next;
    logic                out_vld_reg, out_vld_next;
    mtss_pkg::out_word_t out_reg, out_next;

    logic                rd_en;
    logic [TW-1:0]       rd_addr;
    logic                act_we, note_we, held_we;
    logic [TW-1:0]       wr_addr;
    logic [STEPS-1:0]    act_wdata, act_rdata, act_row;
    logic [NW-1:0]       note_wdata, note_rdata, note_row;
    logic [HW-1:0]       held_wdata, held_rdata, held_row;

    logic                out_free;
    logic                is_tick;
    logic                hit;
    logic                adv;
    logic [SW-1:0]       estp;
    logic [6:0]          fired_note;
    mtss_pkg::out_word_t ev;

    mtss_ram #(.WIDTH(STEPS), .DEPTH(TRACKS)) u_act_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (wr_addr),
        .wdata (act_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (act_rdata)
    );

    mtss_ram #(.WIDTH(NW), .DEPTH(TRACKS)) u_note_ram (
        .clk   (clk),
        .we    (note_we),
        .waddr (wr_addr),
        .wdata (note_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (note_rdata)
    );

    mtss_ram #(.WIDTH(HW), .DEPTH(TRACKS)) u_held_ram (
        .clk   (clk),
        .we    (held_we),
        .waddr (wr_addr),
        .wdata (held_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (held_rdata)
    );

    // rows never written read as their reset contents
    assign act_row  = act_vld_reg[rd_row_reg]  ? act_rdata  : '0;
    assign note_row = note_vld_reg[rd_row_reg] ? note_rdata : {STEPS{mtss_pkg::NOTE_RESET}};
    assign held_row = held_vld_reg[rd_row_reg] ? held_rdata : '0;

    assign out_free  = !out_vld_reg || evt_ready;
    assign evt_valid = out_vld_reg;
    assign evt       = out_reg;

    always_comb
    begin
        estp       = SW'(cur_reg.stp);
        is_tick    = (cur_reg.kind == mtss_pkg::CMD_TICK);
        fired_note = note_row[fired_reg * 7 +: 7];
        hit        = is_tick ? act_row[fired_reg] : held_row[fired_reg * 8 + 7];
        ev.event_track = 4'(cnt_reg);
        ev.last        = 1'b0;
        if (is_tick)
        begin
            ev.event_kind  = mtss_pkg::EV_NOTE_ON;
            ev.note_number = fired_note;
            ev.velocity    = vel_reg;
        end
        else
        begin
            ev.event_kind  = mtss_pkg::EV_NOTE_OFF;
            ev.note_number = held_row[fired_reg * 8 +: 7];
            ev.velocity    = 7'd0;
        end
        adv = !hit || !pend_vld_reg || out_free;
    end

    always_comb
    begin
        state_next    = state_reg;
        playing_next  = playing_reg;
        pos_next      = pos_reg;
        fired_next    = fired_reg;
        vel_next      = cfg_valid ? cfg_data : vel_reg;
        act_vld_next  = act_vld_reg;
        note_vld_next = note_vld_reg;
        held_vld_next = held_vld_reg;
        cnt_next      = cnt_reg;
        cur_next      = cur_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_vld_next  = out_vld_reg && !evt_ready;
        out_next      = out_reg;

        cmd_pop    = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        act_we     = 1'b0;
        note_we    = 1'b0;
        held_we    = 1'b0;
        wr_addr    = TW'(cur_reg.trk);
        act_wdata  = act_row;
        note_wdata = note_row;
        held_wdata = held_row;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    rd_en    = 1'b1;
                    if (cmd.kind == mtss_pkg::CMD_COPY)
                    begin
                        rd_addr = TW'(cmd.src);
                    end
                    else if (cmd.kind == mtss_pkg::CMD_TICK ||
                             cmd.kind == mtss_pkg::CMD_NOTE_OFF)
                    begin
                        rd_addr = '0;
                    end
                    else
                    begin
                        rd_addr = TW'(cmd.trk);
                    end
                    unique case (cmd.kind) inside
                        mtss_pkg::CMD_TOGGLE, mtss_pkg::CMD_SET_NOTE, mtss_pkg::CMD_COPY:
                        begin
                            state_next = S_EDIT;
                        end
                        mtss_pkg::CMD_CLR_TRACK:
                        begin
                            act_we    = 1'b1;
                            wr_addr   = TW'(cmd.trk);
                            act_wdata = '0;
                            act_vld_next[TW'(cmd.trk)] = 1'b1;
                        end
                        mtss_pkg::CMD_CLR_ALL:
                        begin
                            act_vld_next = '0;
                        end
                        mtss_pkg::CMD_START:
                        begin
                            if (!playing_reg)
                            begin
                                playing_next = 1'b1;
                                pos_next     = '0;
                            end
                        end
                        mtss_pkg::CMD_STOP:
                        begin
                            if (playing_reg)
                            begin
                                playing_next          = 1'b0;
                                held_vld_next         = '0;
                                pend_vld_next         = 1'b1;
                                pend_next.event_kind  = mtss_pkg::EV_ALL_OFF;
                                pend_next.event_track = 4'd0;
                                pend_next.note_number = 7'd0;
                                pend_next.velocity    = 7'd0;
                                pend_next.last        = 1'b0;
                                state_next            = S_FLUSH;
                            end
                        end
                        mtss_pkg::CMD_TICK:
                        begin
                            if (playing_reg)
                            begin
                                fired_next = pos_reg;
                                pos_next   = (pos_reg == LAST_STEP) ? '0 : pos_reg + 1'b1;
                                cnt_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        mtss_pkg::CMD_NOTE_OFF:
                        begin
                            cnt_next   = '0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_EDIT:
            begin
                case (cur_reg.kind)
                    mtss_pkg::CMD_TOGGLE:
                    begin
                        act_we           = 1'b1;
                        act_wdata[estp] = ~act_row[estp];
                        act_vld_next[TW'(cur_reg.trk)] = 1'b1;
                    end
                    mtss_pkg::CMD_SET_NOTE:
                    begin
                        act_we                    = 1'b1;
                        note_we                   = 1'b1;
                        act_wdata[estp]           = 1'b1;
                        note_wdata[estp * 7 +: 7] = cur_reg.note;
                        act_vld_next[TW'(cur_reg.trk)]  = 1'b1;
                        note_vld_next[TW'(cur_reg.trk)] = 1'b1;
                    end
                    default:
                    begin
                        // copy: source rows already read
                        act_we  = 1'b1;
                        note_we = 1'b1;
                        act_vld_next[TW'(cur_reg.trk)]  = 1'b1;
                        note_vld_next[TW'(cur_reg.trk)] = 1'b1;
                    end
                endcase
                state_next = S_IDLE;
            end

            S_SCAN:
            begin
                wr_addr = cnt_reg;
                if (is_tick)
                begin
                    held_wdata[fired_reg * 8 +: 8] = {1'b1, fired_note};
                end
                else
                begin
                    held_wdata[fired_reg * 8 +: 8] = 8'd0;
                end
                if (adv)
                begin
                    if (hit)
                    begin
                        held_we                = 1'b1;
                        held_vld_next[cnt_reg] = 1'b1;
                        if (pend_vld_reg)
                        begin
                            out_vld_next = 1'b1;
                            out_next     = pend_reg;
                        end
                        pend_vld_next = 1'b1;
                        pend_next     = ev;
                    end
                    if (cnt_reg == LAST_TRK)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = cnt_reg + 1'b1;
                    end
                end
            end

            S_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_row_next = rd_en ? rd_addr : rd_row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            playing_reg  <= 1'b0;
            pos_reg      <= '0;
            fired_reg    <= '0;
            vel_reg      <= mtss_pkg::VEL_RESET;
            act_vld_reg  <= '0;
            note_vld_reg <= '0;
            held_vld_reg <= '0;
            cnt_reg      <= '0;
            rd_row_reg   <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            playing_reg  <= playing_next;
            pos_reg      <= pos_next;
            fired_reg    <= fired_next;
            vel_reg      <= vel_next;
            act_vld_reg  <= act_vld_next;
            note_vld_reg <= note_vld_next;
            held_vld_reg <= held_vld_next;
            cnt_reg      <= cnt_next;
            rd_row_reg   <= rd_row_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    `ASSERT_NEVER(a_idle_no_pend, clk, rst_n, (state_reg == S_IDLE) && pend_vld_reg)
    `ASSERT_AT(a_scan_row_match, clk, rst_n, (state_reg == S_SCAN) |-> (cnt_reg == rd_row_reg))
    `ASSERT_AT(a_stop_flushes, clk, rst_n, $fell(playing_reg) |-> (state_reg == S_FLUSH) && pend_vld_reg)
    `ASSERT_AT(a_tick_advanced, clk, rst_n, (state_reg == S_SCAN) && is_tick |-> (fired_reg != pos_reg))

endmodule

>>> src/multi_track_step_sequencer.sv
// ---------------------------------------------------------------------------
// multi_track_step_sequencer
// Step sequencer with a TRACKS x STEPS pattern store, edit commands and
// tick-driven note-on/note-off event generation.
// ---------------------------------------------------------------------------
//  channel  | signals                        | word
//  ---------+--------------------------------+---------------------------
//  item     | item_valid / item_ready / item | op, track, step, scale, src
//  event    | evt_valid / evt_ready / evt    | kind, track, note, vel, last
//  config   | cfg_valid / cfg_ready / cfg_data | note velocity (7 bits)
//
//  Back end: clears act from idle, other edits pass an edit state, and stop
//  while playing flushes an all-off event. Step and note-off ticks read one
//  row of the pattern and held stores per track, one per cycle unless stalled.
//  A two-word command queue lets input words arrive while a tick scans.
//  Event backpressure stalls the scan only when a note must be emitted.
//  No clearing pass after reset: per-row valid bits stand in for reset.
// ---------------------------------------------------------------------------
module multi_track_step_sequencer #(
    parameter int TRACKS = 16,
    parameter int STEPS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  mtss_pkg::in_word_t  item,
    output logic                evt_valid,
    input  logic                evt_ready,
    output mtss_pkg::out_word_t evt,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [6:0]          cfg_data
);

    logic           cmd_valid;
    logic           cmd_pop;
    mtss_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    mtss_front #(.TRACKS(TRACKS), .STEPS(STEPS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    mtss_back #(.TRACKS(TRACKS), .STEPS(STEPS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt)
    );

endmodule
